// ===== rtl/rcsit_pkg.sv =====
// shared types and status codes for the refcounted shared id table
package rcsit_pkg;

	localparam logic [2:0] ST_OPEN_HIT     = 3'd0;
	localparam logic [2:0] ST_OPEN_NEW     = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
	localparam logic [2:0] ST_COUNT_FULL   = 3'd3;
	localparam logic [2:0] ST_CLOSE_SHARED = 3'd4;
	localparam logic [2:0] ST_CLOSE_FREED  = 3'd5;

	localparam logic REQ_OPEN  = 1'b0;
	localparam logic REQ_CLOSE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] seg_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       not_found;
		logic [5:0] slot_index;
		logic [7:0] ref_count;
	} rsp_t;

endpackage

// ===== rtl/rcsit_mem.sv =====
// slot storage: identifier and count arrays, one write and one registered read port
module rcsit_mem #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6,
	parameter int CNT_W   = 8
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [31:0]      rd_id,
	output logic [CNT_W-1:0] rd_cnt,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [31:0]      wr_id,
	input  logic [CNT_W-1:0] wr_cnt
);

	logic [31:0]      id_mem  [ENTRIES];
	logic [CNT_W-1:0] cnt_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr]  <= wr_id;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_id  <= id_mem[rd_addr];
			rd_cnt <= cnt_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/rcsit_seq.sv =====
// sequencer: clearing pass, slot scan with one compare unit, decision and write-back
module rcsit_seq #(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNT_MAX     = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  rcsit_pkg::req_t  req,
	output logic             res_valid,
	input  logic             res_ready,
	output rcsit_pkg::rsp_t  res
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(COUNT_MAX + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(COUNT_MAX);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DECIDE = 5'b01000,
		S_PUSH   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] addr_q;
	logic             iss_q;
	logic             close_q;
	logic [31:0]      key_q;
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	rcsit_pkg::rsp_t  res_q;

	logic             rd_en;
	logic [31:0]      rd_id;
	logic [CNT_W-1:0] rd_cnt;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_id;
	logic [CNT_W-1:0] wr_cnt;
	logic             match;
	logic             is_free;
	logic             accept;
	rcsit_pkg::rsp_t  dec;
	logic [CNT_W-1:0] new_cnt;
	logic [IDX_W-1:0] dec_idx;
	logic             dec_has_slot;
	logic [IDX_W+5:0] idx_wide;
	logic [CNT_W+7:0] cnt_wide;

	rcsit_mem #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_id   (rd_id),
		.rd_cnt  (rd_cnt),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_id   (wr_id),
		.wr_cnt  (wr_cnt)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rd_en     = (state_q == S_SCAN) && iss_q;
	assign is_free   = (rd_cnt == '0);
	assign match     = rd_vld_s1 && !is_free && (rd_id == key_q);
	assign res_valid = (state_q == S_PUSH);
	assign res       = res_q;

	// decision and write-back values, and the clearing-pass writes
	always_comb begin
		dec          = '0;
		new_cnt      = '0;
		dec_idx      = '0;
		dec_has_slot = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = addr_q;
		wr_id        = key_q;
		wr_cnt       = '0;
		if (!close_q) begin
			if (hit_found_q) begin
				dec_idx      = hit_idx_q;
				dec_has_slot = 1'b1;
				if (hit_cnt_q >= CNT_MAX) begin
					dec.status = rcsit_pkg::ST_COUNT_FULL;
					new_cnt    = hit_cnt_q;
				end else begin
					dec.status = rcsit_pkg::ST_OPEN_HIT;
					new_cnt    = hit_cnt_q + CNT_ONE;
					wr_en      = 1'b1;
				end
			end else if (free_found_q) begin
				dec.status   = rcsit_pkg::ST_OPEN_NEW;
				dec_idx      = free_idx_q;
				dec_has_slot = 1'b1;
				new_cnt      = CNT_ONE;
				wr_en        = 1'b1;
			end else begin
				dec.status = rcsit_pkg::ST_TABLE_FULL;
			end
		end else begin
			if (hit_found_q) begin
				dec_idx      = hit_idx_q;
				dec_has_slot = 1'b1;
				new_cnt      = hit_cnt_q - CNT_ONE;
				wr_en        = 1'b1;
				if (new_cnt != '0) begin
					dec.status = rcsit_pkg::ST_CLOSE_SHARED;
				end else begin
					dec.status = rcsit_pkg::ST_CLOSE_FREED;
					wr_id      = '0;
				end
			end else begin
				dec.status    = rcsit_pkg::ST_CLOSE_FREED;
				dec.not_found = 1'b1;
			end
		end
		idx_wide       = {6'b0, dec_idx};
		cnt_wide       = {8'b0, new_cnt};
		dec.slot_index = dec_has_slot ? idx_wide[5:0] : 6'b0;
		dec.ref_count  = cnt_wide[7:0];
		if (state_q == S_DECIDE) begin
			wr_addr = dec_idx;
			wr_cnt  = new_cnt;
		end else begin
			wr_en = 1'b0;
		end
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = addr_q;
			wr_id   = '0;
			wr_cnt  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			iss_q        <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_en;
			rd_last_s1 <= rd_en && (addr_q == LAST_IDX);
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + IDX_ONE;
					if (addr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						addr_q       <= '0;
						iss_q        <= 1'b1;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						addr_q <= addr_q + IDX_ONE;
						if (addr_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end
					end
					if (match && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (rd_vld_s1 && is_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			close_q <= req.req_type;
			key_q   <= req.seg_id;
		end
		if (state_q == S_SCAN && match && !hit_found_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_cnt_q <= rd_cnt;
		end
		if (state_q == S_SCAN && rd_vld_s1 && is_free && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (state_q == S_DECIDE) begin
			res_q <= dec;
		end
	end

`ifndef NO_ASSERTIONS
	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (!iss_q && !rd_vld_s1))
		else $error("decision taken before scan finished");

	a_hit_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_found_q && (state_q == S_DECIDE)) |-> (hit_cnt_q != '0))
		else $error("matched slot has zero count");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == S_SCAN) && (addr_q == '0) && iss_q))
		else $error("accepted request did not start scan");

	a_not_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.not_found) |-> (res.status == rcsit_pkg::ST_CLOSE_FREED))
		else $error("not_found with wrong status");
`endif

endmodule

// ===== rtl/refcounted_shared_id_table.sv =====
// top level of the refcounted shared id table with its result register
//
// Requests (req_valid/req_ready/req) carry an open or close of a segment id.
// Each request gives exactly one response (rsp_valid/rsp_ready/rsp) with a
// status, a not-found flag, the slot index and the count after the request.
// A request is taken only while the sequencer is idle. Its lookup reads the
// slot memory one entry per cycle through its single read port; no new
// request is taken until the response has moved into the output register.
// After reset the block runs a clearing pass that frees every slot;
// req_ready stays low during it.
// The output register holds a response while the receiver stalls; the next
// request may be accepted and scanned meanwhile, and its response waits in
// the sequencer until the register drains.
module refcounted_shared_id_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNT_MAX     = 255
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rcsit_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rcsit_pkg::rsp_t rsp
);

	logic            res_valid;
	logic            res_ready;
	rcsit_pkg::rsp_t res;
	logic            rsp_valid_q;
	rcsit_pkg::rsp_t rsp_q;

	rcsit_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_MAX     (COUNT_MAX)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

// ===== bench/tb_refcounted_shared_id_table.sv =====
// testbench for the refcounted shared id table: directed requests, then phased random requests
module tb_refcounted_shared_id_table;

	localparam int SLOTS          = 64;
	localparam int COUNT_CEIL     = 255;
	localparam int POOL_SIZE      = 80;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int QUIET_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 2 * (SLOTS + 3);
	localparam int HOLD_CYCLES    = 700;
	localparam int HOLD_AFTER_RSP = 300;

	typedef enum {PH_HAMMER, PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} phase_kind_t;

	typedef struct packed {
		rcsit_pkg::req_t r;
		logic            typed;
		rcsit_pkg::rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	rcsit_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rcsit_pkg::rsp_t rsp;

	logic [31:0] seg_key [SLOTS] = '{default: '0};
	int unsigned seg_count [SLOTS] = '{default: 0};
	logic [31:0] seg_pool [POOL_SIZE];
	rcsit_pkg::rsp_t pending_rsps [$];
	bit idle_en = 1'b1;
	int items_sent = 0;
	int rsp_total = 0;
	int fails = 0;

	dir_row_t directed_rows [22] = '{
		'{'{rcsit_pkg::REQ_OPEN,  32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd0, 8'd1}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_OPEN_HIT,     1'b0, 6'd0, 8'd2}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_SHARED, 1'b0, 6'd0, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b1, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_OPEN,  32'hFFFF_FFFF}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd0, 8'd1}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h0000_0001}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd1, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b1, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h8000_0000}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd2, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'hFFFF_FFFF}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h8000_0000}, 1'b1,
			'{rcsit_pkg::ST_OPEN_HIT,     1'b0, 6'd2, 8'd2}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h7FFF_FFFF}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd0, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'hFFFF_FFFF}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b1, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_OPEN,  32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_OPEN_NEW,     1'b0, 6'd3, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0001}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd1, 8'd0}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h7FFF_FFFF}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd0, 8'd0}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h8000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_SHARED, 1'b0, 6'd2, 8'd1}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h8000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd2, 8'd0}},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h0000_0000}, 1'b1,
			'{rcsit_pkg::ST_CLOSE_FREED,  1'b0, 6'd3, 8'd0}},
		'{'{rcsit_pkg::REQ_OPEN,  32'hA5A5_A5A5}, 1'b0, '0},
		'{'{rcsit_pkg::REQ_CLOSE, 32'h5A5A_5A5A}, 1'b0, '0},
		'{'{rcsit_pkg::REQ_CLOSE, 32'hA5A5_A5A5}, 1'b0, '0}
	};

	refcounted_shared_id_table #(
		.TABLE_ENTRIES(SLOTS),
		.COUNT_MAX(COUNT_CEIL)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic rcsit_pkg::rsp_t apply_to_table(input rcsit_pkg::req_t r);
		rcsit_pkg::rsp_t o;
		int hit;
		int free_slot;
		o = '0;
		hit = -1;
		free_slot = -1;
		// walk downward so the lowest matching and lowest free slot win
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (seg_count[i] != 0 && seg_key[i] == r.seg_id) hit = i;
			if (seg_count[i] == 0) free_slot = i;
		end
		if (r.req_type == rcsit_pkg::REQ_OPEN) begin
			if (hit >= 0) begin
				if (seg_count[hit] >= COUNT_CEIL) begin
					o.status = rcsit_pkg::ST_COUNT_FULL;
				end else begin
					seg_count[hit]++;
					o.status = rcsit_pkg::ST_OPEN_HIT;
				end
				o.slot_index = 6'(hit);
				o.ref_count = 8'(seg_count[hit]);
			end else if (free_slot >= 0) begin
				seg_key[free_slot] = r.seg_id;
				seg_count[free_slot] = 1;
				o.status = rcsit_pkg::ST_OPEN_NEW;
				o.slot_index = 6'(free_slot);
				o.ref_count = 8'd1;
			end else begin
				o.status = rcsit_pkg::ST_TABLE_FULL;
			end
		end else if (hit >= 0) begin
			seg_count[hit]--;
			o.slot_index = 6'(hit);
			if (seg_count[hit] != 0) begin
				o.status = rcsit_pkg::ST_CLOSE_SHARED;
				o.ref_count = 8'(seg_count[hit]);
			end else begin
				seg_key[hit] = '0;
				o.status = rcsit_pkg::ST_CLOSE_FREED;
			end
		end else begin
			o.status = rcsit_pkg::ST_CLOSE_FREED;
			o.not_found = 1'b1;
		end
		return o;
	endfunction

	// id of some slot in use, or a pool id when none turns up
	function automatic logic [31:0] live_seg_id();
		int slot;
		for (int tries = 0; tries < 16; tries++) begin
			slot = $urandom_range(SLOTS - 1);
			if (seg_count[slot] != 0) return seg_key[slot];
		end
		return seg_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	task automatic send_req(input rcsit_pkg::req_t r, input logic typed,
		input rcsit_pkg::rsp_t typed_rsp);
		rcsit_pkg::rsp_t predicted;
		@(negedge clk);
		while (idle_en && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (!req_ready);
		predicted = apply_to_table(r);
		pending_rsps.push_back(typed ? typed_rsp : predicted);
		items_sent++;
	endtask

	always @(posedge clk) begin : rsp_check
		rcsit_pkg::rsp_t want;
		bit bad;
		if (rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: response with none pending, got %p", $time, rsp);
				fails++;
			end else begin
				want = pending_rsps.pop_front();
				bad = 1'b0;
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
					bad = 1'b1;
				end
				if (rsp.not_found !== want.not_found) begin
					$display("%0t: not_found expected %0d got %0d", $time, want.not_found,
						rsp.not_found);
					bad = 1'b1;
				end
				if (rsp.slot_index !== want.slot_index) begin
					$display("%0t: slot_index expected %0d got %0d", $time, want.slot_index,
						rsp.slot_index);
					bad = 1'b1;
				end
				if (rsp.ref_count !== want.ref_count) begin
					$display("%0t: ref_count expected %0d got %0d", $time, want.ref_count,
						rsp.ref_count);
					bad = 1'b1;
				end
				if (bad) fails++;
			end
			rsp_total++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
			else quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : rsp_side
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			// one long back-pressure stretch so the block fills and stalls requests
			if (!held && rsp_total >= HOLD_AFTER_RSP) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= !(idle_en && $urandom_range(99) < 31);
			end
		end
	end

	initial begin : stimulus
		rcsit_pkg::req_t r;
		phase_kind_t kind;
		logic [31:0] base;
		logic [31:0] id;
		int phase;
		int n;
		int start;
		int roll;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		seg_pool[0] = '0;
		seg_pool[1] = '1;
		base = $urandom;
		// ids one bit apart from a common base
		for (int i = 2; i < 34; i++) seg_pool[i] = base ^ (32'd1 << (i - 2));
		for (int i = 34; i < POOL_SIZE; i++) seg_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) send_req(directed_rows[i].r, directed_rows[i].typed,
			directed_rows[i].want);

		phase = 0;
		while (items_sent < RANDOM_ITEMS + $size(directed_rows)) begin
			case (phase)
				0: kind = PH_HAMMER;
				1: kind = PH_FILL;
				2: kind = PH_MIX;
				3: kind = PH_DRAIN;
				5: kind = PH_MIX;
				default: kind = phase_kind_t'($urandom_range(4));
			endcase
			idle_en = (phase != 5);
			case (kind)
				PH_HAMMER: begin
					id = seg_pool[$urandom_range(POOL_SIZE - 1)];
					n = (phase == 0) ? COUNT_CEIL + 5 : $urandom_range(60, 8);
					r.seg_id = id;
					r.req_type = rcsit_pkg::REQ_OPEN;
					repeat (n) send_req(r, 1'b0, '0);
					r.req_type = rcsit_pkg::REQ_CLOSE;
					repeat (n + 2) send_req(r, 1'b0, '0);
				end
				PH_FILL: begin
					start = $urandom_range(POOL_SIZE - 1);
					n = $urandom_range(90, 66);
					r.req_type = rcsit_pkg::REQ_OPEN;
					for (int i = 0; i < n; i++) begin
						r.seg_id = seg_pool[(start + i) % POOL_SIZE];
						send_req(r, 1'b0, '0);
					end
				end
				PH_MIX: begin
					n = (phase == 5) ? 250 : $urandom_range(200, 80);
					repeat (n) begin
						roll = $urandom_range(99);
						if (roll < 50) begin
							r.req_type = rcsit_pkg::REQ_OPEN;
							r.seg_id = seg_pool[$urandom_range(POOL_SIZE - 1)];
						end else if (roll < 85) begin
							r.req_type = rcsit_pkg::REQ_CLOSE;
							r.seg_id = live_seg_id();
						end else begin
							r.req_type = rcsit_pkg::REQ_CLOSE;
							r.seg_id = seg_pool[$urandom_range(POOL_SIZE - 1)];
						end
						send_req(r, 1'b0, '0);
					end
				end
				PH_DRAIN: begin
					n = $urandom_range(120, 60);
					r.req_type = rcsit_pkg::REQ_CLOSE;
					repeat (n) begin
						r.seg_id = ($urandom_range(9) == 0) ? $urandom : live_seg_id();
						send_req(r, 1'b0, '0);
					end
				end
				default: begin
					n = $urandom_range(60, 20);
					repeat (n) begin
						r.req_type = 1'($urandom_range(1));
						r.seg_id = $urandom_range(1) ? $urandom :
							seg_pool[$urandom_range(POOL_SIZE - 1)];
						send_req(r, 1'b0, '0);
					end
				end
			endcase
			phase++;
		end
		idle_en = 1'b1;

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rcsit_pkg.sv
rtl/rcsit_mem.sv
rtl/rcsit_seq.sv
rtl/refcounted_shared_id_table.sv
bench/tb_refcounted_shared_id_table.sv
